// File: sv/tnic_pkg.sv
// Shared types, constants and codes for the tree node IPv6 address calculator.
`timescale 1ns / 1ps

package tnic_pkg;

    // Node ID width and derived widths.
    localparam int NODE_BITS = 64;
    localparam int TZ_BITS   = $clog2(NODE_BITS);
    localparam int DEPTH_W   = 7;
    localparam int HOST_W    = 7;
    localparam int ADDR_BITS = 128;
    localparam int HALF_BITS = 64;
    localparam int PLEN_W    = 8;
    localparam int MODE_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LOW  = 2'd3;

    localparam logic [DEPTH_W-1:0] TREE_DEPTH_RST = 7'd8;

    // Query modes.
    localparam logic [MODE_W-1:0] MODE_RANK        = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PARENT      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_LEFT        = 4'd2;
    localparam logic [MODE_W-1:0] MODE_RIGHT       = 4'd3;
    localparam logic [MODE_W-1:0] MODE_TOP_CFG     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_BOT_CFG     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_TOP_ROUTE   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LEFT_ROUTE  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_RIGHT_ROUTE = 4'd8;
    localparam logic [MODE_W-1:0] MODE_BOT_ROUTE   = 4'd9;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Decoded query, handed from the decode stage to the network stage.
    typedef struct packed {
        t_status               status;
        logic [NODE_BITS-1:0]  node_value;
        logic [NODE_BITS-1:0]  net_id;
        logic                  has_addr;
        logic                  set_lsb;
        logic                  route_mask;
        logic [PLEN_W-1:0]     plen;
    } t_dec;

endpackage

// File: sv/tnic_decode.sv
// Query decode: validity, rank, related node and prefix length selection.
`timescale 1ns / 1ps

module tnic_decode
    import tnic_pkg::*;
(
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [NODE_BITS-1:0] i_node_id,
    input  logic [DEPTH_W-1:0]   i_tree_depth,
    input  logic [HOST_W-1:0]    i_host_bits,
    output t_dec                 o_dec
);

    logic [DEPTH_W-1:0]   depth;
    logic [NODE_BITS-1:0] hi_mask;
    logic                 bad;
    logic [TZ_BITS-1:0]   tz;
    logic [TZ_BITS:0]     k;
    logic [DEPTH_W-1:0]   rank;
    logic [PLEN_W-1:0]    hd_sum;
    logic [PLEN_W-1:0]    tpl;
    logic [PLEN_W-1:0]    host_plen;
    logic [PLEN_W:0]      route_sum;
    logic [PLEN_W-1:0]    route_plen;
    logic [NODE_BITS-1:0] up_node;
    logic [NODE_BITS-1:0] step;
    logic [NODE_BITS-1:0] left_node;
    logic [NODE_BITS-1:0] right_node;
    logic                 is_root;
    logic                 is_leaf;
    logic                 host_zero;

    always_comb begin
        depth = (i_tree_depth > DEPTH_W'(NODE_BITS)) ? DEPTH_W'(NODE_BITS) : i_tree_depth;

        for (int i = 0; i < NODE_BITS; i++) begin
            hi_mask[i] = (i >= int'(depth));
        end
        bad = (depth == '0) || (i_node_id == '0) || (|(i_node_id & hi_mask));

        // Lowest set bit of the node ID.
        tz = '0;
        for (int i = NODE_BITS - 1; i >= 0; i--) begin
            if (i_node_id[i]) begin
                tz = TZ_BITS'(i);
            end
        end

        rank       = depth - DEPTH_W'(tz);
        hd_sum     = PLEN_W'(i_host_bits) + PLEN_W'(depth);
        tpl        = hd_sum[PLEN_W-1] ? '0 : (PLEN_W'(ADDR_BITS) - hd_sum);
        host_plen  = PLEN_W'(ADDR_BITS) - PLEN_W'(i_host_bits);
        route_sum  = (PLEN_W+1)'(tpl) + (PLEN_W+1)'(rank);
        route_plen = (route_sum > (PLEN_W+1)'(ADDR_BITS)) ? PLEN_W'(ADDR_BITS)
                                                           : route_sum[PLEN_W-1:0];

        k          = (TZ_BITS+1)'(tz) + 1'b1;
        up_node    = (i_node_id & ({NODE_BITS{1'b1}} << k))
                   | (NODE_BITS'(1) << k);
        step       = NODE_BITS'(1) << (tz - 1'b1);
        left_node  = i_node_id - step;
        right_node = i_node_id + step;

        is_root   = (rank <= DEPTH_W'(1));
        is_leaf   = (rank >= depth);
        host_zero = (i_host_bits == '0);

        o_dec            = '0;
        o_dec.status     = ST_NONE;
        o_dec.net_id     = i_node_id;

        if (i_mode <= MODE_BOT_ROUTE) begin
            if (bad) begin
                o_dec.status = ST_BAD;
            end else begin
                o_dec.status = ST_OK;
                case (i_mode)
                    MODE_RANK: begin
                        o_dec.node_value = NODE_BITS'(rank);
                    end
                    MODE_PARENT: begin
                        if (is_root) o_dec.status = ST_NONE;
                        else         o_dec.node_value = up_node;
                    end
                    MODE_LEFT: begin
                        if (is_leaf) o_dec.status = ST_NONE;
                        else         o_dec.node_value = left_node;
                    end
                    MODE_RIGHT: begin
                        if (is_leaf) o_dec.status = ST_NONE;
                        else         o_dec.node_value = right_node;
                    end
                    MODE_TOP_CFG: begin
                        if (!host_zero) begin
                            o_dec.status = ST_NONE;
                        end else begin
                            o_dec.has_addr = 1'b1;
                            o_dec.plen     = PLEN_W'(ADDR_BITS);
                        end
                    end
                    MODE_BOT_CFG: begin
                        if (host_zero) begin
                            o_dec.status = ST_NONE;
                        end else begin
                            o_dec.has_addr = 1'b1;
                            o_dec.set_lsb  = 1'b1;
                            o_dec.plen     = host_plen;
                        end
                    end
                    MODE_TOP_ROUTE: begin
                        if (is_root) begin
                            o_dec.status = ST_NONE;
                        end else begin
                            o_dec.has_addr = 1'b1;
                            o_dec.net_id   = up_node;
                            o_dec.plen     = host_plen;
                        end
                    end
                    MODE_LEFT_ROUTE, MODE_RIGHT_ROUTE: begin
                        if (is_leaf) begin
                            o_dec.status = ST_NONE;
                        end else begin
                            o_dec.has_addr = 1'b1;
                            o_dec.net_id   = (i_mode == MODE_LEFT_ROUTE) ? left_node
                                                                         : right_node;
                            // Child on the last rank: the child's own LAN prefix.
                            if (rank + 1'b1 == depth) begin
                                o_dec.plen = host_plen;
                            end else begin
                                o_dec.plen       = route_plen;
                                o_dec.route_mask = 1'b1;
                            end
                        end
                    end
                    MODE_BOT_ROUTE: begin
                        if (host_zero) begin
                            o_dec.status = ST_NONE;
                        end else begin
                            o_dec.has_addr = 1'b1;
                            o_dec.plen     = host_plen;
                        end
                    end
                    default: begin
                        o_dec.status = ST_NONE;
                    end
                endcase
            end
        end
    end

endmodule

// File: sv/tnic_net.sv
// Network stage: shift node ID past the host bits, merge prefix, apply route mask.
`timescale 1ns / 1ps

module tnic_net
    import tnic_pkg::*;
(
    input  t_dec                 i_dec,
    input  logic [HOST_W-1:0]    i_host_bits,
    input  logic [HALF_BITS-1:0] i_prefix_high,
    input  logic [HALF_BITS-1:0] i_prefix_low,
    output logic [1:0]           o_status,
    output logic [NODE_BITS-1:0] o_node_value,
    output logic [HALF_BITS-1:0] o_addr_high,
    output logic [HALF_BITS-1:0] o_addr_low,
    output logic [PLEN_W-1:0]    o_prefix_len
);

    function automatic logic [ADDR_BITS-1:0] top_mask(input logic [PLEN_W-1:0] n);
        top_mask = ~({ADDR_BITS{1'b1}} >> n);
    endfunction

    logic [ADDR_BITS-1:0] shifted;
    logic [ADDR_BITS-1:0] net;

    always_comb begin
        shifted = ADDR_BITS'(i_dec.net_id) << i_host_bits;
        net     = shifted | ({i_prefix_high, i_prefix_low}
                             & top_mask(PLEN_W'(ADDR_BITS) - PLEN_W'(i_host_bits)));
        if (i_dec.set_lsb) begin
            net[0] = 1'b1;
        end
        if (i_dec.route_mask) begin
            net = net & top_mask(i_dec.plen);
        end
        if (!i_dec.has_addr) begin
            net = '0;
        end

        o_status     = i_dec.status;
        o_node_value = i_dec.node_value;
        o_addr_high  = net[ADDR_BITS-1:HALF_BITS];
        o_addr_low   = net[HALF_BITS-1:0];
        o_prefix_len = i_dec.has_addr ? i_dec.plen : '0;
    end

endmodule

// File: sv/tree_node_ipv6_address_calc_core.sv
// Top level: three-stage pipeline answering tree node rank, neighbor, address and route queries.
// Queries pass the input, decode and result registers; a stage advances when the next is free.
// Throughput: one transaction per cycle while the receiver keeps i_out_ready high.
// o_in_ready follows i_out_ready combinationally when all three stages hold a transaction.
// Reset (synchronous, i_rst_n low): pipeline emptied, tree_depth = 8, host_bits = 0, prefix = 0.
// Configuration writes are never stalled (o_cfg_ready is always high).
`timescale 1ns / 1ps

module tree_node_ipv6_address_calc_core
    import tnic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,

    // Query channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [NODE_BITS-1:0] i_node_id,

    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [NODE_BITS-1:0] o_node_value,
    output logic [HALF_BITS-1:0] o_addr_high,
    output logic [HALF_BITS-1:0] o_addr_low,
    output logic [PLEN_W-1:0]    o_prefix_len
);

    // Configuration registers
    logic [DEPTH_W-1:0]   r_tree_depth;
    logic [HOST_W-1:0]    r_host_bits;
    logic [HALF_BITS-1:0] r_prefix_high;
    logic [HALF_BITS-1:0] r_prefix_low;

    // Pipeline stage registers
    logic                 r_in_valid;
    logic [MODE_W-1:0]    r_mode;
    logic [NODE_BITS-1:0] r_node_id;

    logic                 r_mid_valid;
    t_dec                 r_dec;

    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [NODE_BITS-1:0] r_node_value;
    logic [HALF_BITS-1:0] r_addr_high;
    logic [HALF_BITS-1:0] r_addr_low;
    logic [PLEN_W-1:0]    r_prefix_len;

    // Stage outputs
    t_dec                 n_dec;
    logic [1:0]           n_status;
    logic [NODE_BITS-1:0] n_node_value;
    logic [HALF_BITS-1:0] n_addr_high;
    logic [HALF_BITS-1:0] n_addr_low;
    logic [PLEN_W-1:0]    n_prefix_len;

    // Advance enables: a stage moves when it is empty or the next one takes its data.
    logic adv_out;
    logic adv_mid;
    logic adv_in;

    assign adv_out    = !r_out_valid || i_out_ready;
    assign adv_mid    = !r_mid_valid || adv_out;
    assign adv_in     = !r_in_valid  || adv_mid;
    assign o_in_ready = adv_in;

    assign o_cfg_ready = 1'b1;

    // Holds config; the user writes it only while no transaction is in flight; not checked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth  <= TREE_DEPTH_RST;
            r_host_bits   <= '0;
            r_prefix_high <= '0;
            r_prefix_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TREE_DEPTH:  r_tree_depth  <= i_cfg_data[DEPTH_W-1:0];
                CFG_HOST_BITS:   r_host_bits   <= i_cfg_data[HOST_W-1:0];
                CFG_PREFIX_HIGH: r_prefix_high <= i_cfg_data;
                CFG_PREFIX_LOW:  r_prefix_low  <= i_cfg_data;
                default:         r_prefix_low  <= r_prefix_low;
            endcase
        end
    end

    // Decode stage: validity check, rank, parent or child ID, prefix length.
    tnic_decode u_decode (
        .i_mode       (r_mode),
        .i_node_id    (r_node_id),
        .i_tree_depth (r_tree_depth),
        .i_host_bits  (r_host_bits),
        .o_dec        (n_dec)
    );

    // Network stage: build the 128-bit address or route network.
    tnic_net u_net (
        .i_dec         (r_dec),
        .i_host_bits   (r_host_bits),
        .i_prefix_high (r_prefix_high),
        .i_prefix_low  (r_prefix_low),
        .o_status      (n_status),
        .o_node_value  (n_node_value),
        .o_addr_high   (n_addr_high),
        .o_addr_low    (n_addr_low),
        .o_prefix_len  (n_prefix_len)
    );

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in)  r_in_valid  <= i_in_valid;
            if (adv_mid) r_mid_valid <= r_in_valid;
            if (adv_out) r_out_valid <= r_mid_valid;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_mode    <= i_mode;
            r_node_id <= i_node_id;
        end
        if (adv_mid) begin
            r_dec <= n_dec;
        end
        if (adv_out) begin
            r_status     <= n_status;
            r_node_value <= n_node_value;
            r_addr_high  <= n_addr_high;
            r_addr_low   <= n_addr_low;
            r_prefix_len <= n_prefix_len;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_node_value = r_node_value;
    assign o_addr_high  = r_addr_high;
    assign o_addr_low   = r_addr_low;
    assign o_prefix_len = r_prefix_len;

endmodule

// File: tb/sv/tnic_tb_pkg.sv
// Answer board for the tree node IPv6 address calculator: register mirror, query answers, result checks.
`timescale 1ns / 1ps

package tnic_tb_pkg;

    import tnic_pkg::*;

    // One answer as it leaves the result channel.
    typedef struct packed {
        t_status               status;
        logic [NODE_BITS-1:0]  node_value;
        logic [HALF_BITS-1:0]  addr_high;
        logic [HALF_BITS-1:0]  addr_low;
        logic [PLEN_W-1:0]     prefix_len;
    } t_answer;

    class answer_board;

        int unsigned            tree_depth;
        int unsigned            host_bits;
        logic [HALF_BITS-1:0]   prefix_high;
        logic [HALF_BITS-1:0]   prefix_low;
        t_answer                answers_due[$];
        int unsigned            errors;
        int unsigned            seen_ok;
        int unsigned            seen_none;
        int unsigned            seen_bad;

        function new();
            tree_depth  = TREE_DEPTH_RST;
            host_bits   = 0;
            prefix_high = '0;
            prefix_low  = '0;
            errors      = 0;
            seen_ok     = 0;
            seen_none   = 0;
            seen_bad    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_TREE_DEPTH:  tree_depth  = data[DEPTH_W-1:0];
                CFG_HOST_BITS:   host_bits   = data[HOST_W-1:0];
                CFG_PREFIX_HIGH: prefix_high = data;
                CFG_PREFIX_LOW:  prefix_low  = data;
                default: ;
            endcase
        endfunction

        // Top n bits of a 128-bit value, n in 0..128.
        function logic [ADDR_BITS-1:0] top_bits(int unsigned n);
            return ~({ADDR_BITS{1'b1}} >> n);
        endfunction

        // Node LAN: ID above the host bits, tree prefix in the remaining top bits.
        function logic [ADDR_BITS-1:0] node_network(logic [NODE_BITS-1:0] id);
            return ({{HALF_BITS{1'b0}}, id} << host_bits) |
                   ({prefix_high, prefix_low} & top_bits(ADDR_BITS - host_bits));
        endfunction

        function t_answer answer_query(logic [MODE_W-1:0] mode, logic [NODE_BITS-1:0] node);
            t_answer                ans;
            int unsigned            depth;
            int unsigned            tz;
            int unsigned            rank;
            int unsigned            tpl;
            int unsigned            plen;
            logic [NODE_BITS-1:0]   other;
            logic [NODE_BITS-1:0]   low_bits;
            logic [ADDR_BITS-1:0]   net;
            t_status                st;
            ans = '{status: ST_NONE, node_value: '0, addr_high: '0, addr_low: '0,
                    prefix_len: '0};
            if (mode > MODE_BOT_ROUTE)
                return ans;
            depth = (tree_depth > NODE_BITS) ? NODE_BITS : tree_depth;
            if (depth == 0 || node == '0 || (depth < NODE_BITS && (node >> depth) != '0)) begin
                ans.status = ST_BAD;
                return ans;
            end
            tz = 0;
            while (tz < NODE_BITS - 1 && node[tz] == 1'b0)
                tz++;
            rank  = depth - tz;
            tpl   = (host_bits + depth >= ADDR_BITS) ? 0 : ADDR_BITS - host_bits - depth;
            st    = ST_OK;
            other = '0;
            net   = '0;
            plen  = 0;

            // Neighbor in the tree: parent one level up, children half a step aside.
            case (mode)
                MODE_PARENT, MODE_TOP_ROUTE: begin
                    if (rank <= 1) begin
                        st = ST_NONE;
                    end else begin
                        low_bits = (64'd1 << (tz + 1)) - 64'd1;
                        other = (node & ~low_bits) | (64'd1 << (tz + 1));
                    end
                end
                MODE_LEFT, MODE_RIGHT, MODE_LEFT_ROUTE, MODE_RIGHT_ROUTE: begin
                    if (rank >= depth) begin
                        st = ST_NONE;
                    end else begin
                        low_bits = 64'd1 << (tz - 1);
                        other = (mode == MODE_LEFT || mode == MODE_LEFT_ROUTE) ?
                                node - low_bits : node + low_bits;
                    end
                end
                default: ;
            endcase

            if (st == ST_OK) begin
                case (mode)
                    MODE_RANK: ans.node_value = rank;
                    MODE_PARENT, MODE_LEFT, MODE_RIGHT: ans.node_value = other;
                    MODE_TOP_CFG: begin
                        if (host_bits != 0) begin
                            st = ST_NONE;
                        end else begin
                            net  = node_network(node);
                            plen = ADDR_BITS;
                        end
                    end
                    MODE_BOT_CFG: begin
                        if (host_bits == 0) begin
                            st = ST_NONE;
                        end else begin
                            net  = node_network(node) | 128'd1;
                            plen = ADDR_BITS - host_bits;
                        end
                    end
                    MODE_TOP_ROUTE: begin
                        net  = node_network(other);
                        plen = ADDR_BITS - host_bits;
                    end
                    MODE_LEFT_ROUTE, MODE_RIGHT_ROUTE: begin
                        net = node_network(other);
                        // just above the leaves the child LAN itself is the route
                        if (rank + 1 == depth) begin
                            plen = ADDR_BITS - host_bits;
                        end else begin
                            plen = tpl + rank;
                            if (plen > ADDR_BITS)
                                plen = ADDR_BITS;
                            net &= top_bits(plen);
                        end
                    end
                    MODE_BOT_ROUTE: begin
                        if (host_bits == 0) begin
                            st = ST_NONE;
                        end else begin
                            net  = node_network(node);
                            plen = ADDR_BITS - host_bits;
                        end
                    end
                    default: ;
                endcase
            end

            ans.status = st;
            if (st == ST_OK) begin
                ans.addr_high  = net[ADDR_BITS-1:HALF_BITS];
                ans.addr_low   = net[HALF_BITS-1:0];
                ans.prefix_len = plen[PLEN_W-1:0];
            end else begin
                ans.node_value = '0;
            end
            return ans;
        endfunction

        function void note_query(logic [MODE_W-1:0] mode, logic [NODE_BITS-1:0] node);
            answers_due.push_back(answer_query(mode, node));
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_answer got);
            t_answer want;
            if (answers_due.size() == 0) begin
                $display("%0t: result with no query outstanding, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("node_value", want.node_value, got.node_value);
            compare_field("addr_high", want.addr_high, got.addr_high);
            compare_field("addr_low", want.addr_low, got.addr_low);
            compare_field("prefix_len", 64'(want.prefix_len), 64'(got.prefix_len));
            case (got.status)
                ST_OK:   seen_ok++;
                ST_NONE: seen_none++;
                default: seen_bad++;
            endcase
        endfunction

    endclass

endpackage

// File: tb/sv/tb_tree_node_ipv6_address_calc_core.sv
// Testbench top: random and directed tree node queries over many register settings, checked live.
`timescale 1ns / 1ps

module tb_tree_node_ipv6_address_calc_core;

    import tnic_pkg::*;
    import tnic_tb_pkg::*;

    // Mode codes outside the defined range; the block answers them with no result.
    localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = 4'd10;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = 4'd15;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SQUEEZE_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned PHASE_ITEMS    = 80;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [MODE_W-1:0]    i_mode;
    logic [NODE_BITS-1:0] i_node_id;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic [NODE_BITS-1:0] o_node_value;
    logic [HALF_BITS-1:0] o_addr_high;
    logic [HALF_BITS-1:0] o_addr_low;
    logic [PLEN_W-1:0]    o_prefix_len;

    answer_board  board = new();
    int unsigned  sender_pct;
    int unsigned  stall_pct;
    int unsigned  settings_run;
    int unsigned  queries_sent;
    int unsigned  idle_cycles;
    bit           squeeze_on;
    bit           rx_hold;

    // Directed queries after the root sweep: leaf, penultimate rank, range edges, unknown codes.
    logic [MODE_W-1:0] dir_mode [14] = '{
        MODE_PARENT, MODE_LEFT, MODE_RIGHT, MODE_TOP_ROUTE, MODE_LEFT_ROUTE, MODE_RIGHT_ROUTE,
        MODE_LEFT_ROUTE, MODE_RIGHT_ROUTE,
        MODE_RANK, MODE_RANK, MODE_PARENT, MODE_TOP_CFG,
        MODE_UNKNOWN_LO, MODE_UNKNOWN_HI};
    logic [NODE_BITS-1:0] dir_node [14] = '{
        64'd1, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1,
        64'd2, 64'd2,
        64'd0, 64'd256, {NODE_BITS{1'b1}}, 64'd255,
        64'd0, 64'd0};

    tree_node_ipv6_address_calc_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_node_id    (i_node_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_node_value (o_node_value),
        .o_addr_high  (o_addr_high),
        .o_addr_low   (o_addr_low),
        .o_prefix_len (o_prefix_len)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly defined modes; a few unknown codes mixed in.
    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(0, 99) < 6)
            return MODE_W'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
        return MODE_W'($urandom_range(MODE_RANK, MODE_BOT_ROUTE));
    endfunction

    // Valid nodes with an even spread of ranks, plus some out-of-range noise.
    function automatic logic [NODE_BITS-1:0] pick_node(int unsigned depth_cfg);
        logic [NODE_BITS-1:0] r;
        logic [NODE_BITS-1:0] mask;
        int unsigned          d;
        int unsigned          tz;
        r = {$urandom, $urandom};
        d = (depth_cfg > NODE_BITS) ? NODE_BITS : depth_cfg;
        if (d == 0 || $urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return r;
                2: return '1;
                default: return (d >= NODE_BITS) ? r : ((r << d) | (64'd1 << d));
            endcase
        end
        mask = (d >= NODE_BITS) ? '1 : (64'd1 << d) - 64'd1;
        // pick the rank first: the trailing-zero count fixes it
        tz = $urandom_range(0, d - 1);
        return ((r << tz) | (64'd1 << tz)) & mask;
    endfunction

    // Offer one query; hold valid and payload until the transaction completes.
    task automatic send_query(input logic [MODE_W-1:0] mode, input logic [NODE_BITS-1:0] node);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < sender_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_node_id  <= node;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_query(mode, node);
        queries_sent++;
    endtask

    // Keep cfg valid high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
    endtask

    // Wait until every outstanding answer has come back.
    task automatic drain();
        while (board.answers_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idle(input t_idle idle);
        case (idle)
            IDLE_SENDER:   begin sender_pct = 82; stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_pct = 0;  stall_pct = 82; end
            IDLE_BOTH:     begin sender_pct = 12; stall_pct = 12; end
            default:       begin sender_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // One register setting: program all four registers while idle, then stream queries.
    task automatic run_phase(input int unsigned depth, input int unsigned host,
                             input logic [HALF_BITS-1:0] pfx_high,
                             input logic [HALF_BITS-1:0] pfx_low,
                             input t_idle idle, input int unsigned count, input bit squeeze);
        write_reg(CFG_TREE_DEPTH, CFG_DAT_W'(depth));
        write_reg(CFG_HOST_BITS, CFG_DAT_W'(host));
        write_reg(CFG_PREFIX_HIGH, pfx_high);
        write_reg(CFG_PREFIX_LOW, pfx_low);
        i_cfg_valid <= 1'b0;
        settings_run++;
        set_idle(idle);
        if (squeeze)
            squeeze_on = 1'b1;
        for (int n = 0; n < count; n++)
            send_query(pick_mode(), pick_node(depth));
        i_in_valid <= 1'b0;
        drain();
    endtask

    // Result side: check each completed transaction, then choose next cycle's ready.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
                board.check_result('{status: t_status'(o_status), node_value: o_node_value,
                                     addr_high: o_addr_high, addr_low: o_addr_low,
                                     prefix_len: o_prefix_len});
            i_out_ready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Long receiver hold-off: the sender keeps offering so the pipeline fills and back-pressures.
    initial begin
        wait (squeeze_on);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog: end the run if no transaction on any channel for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL tree_node_ipv6_address_calc_core");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TREE_DEPTH;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_RANK;
        i_node_id   = '0;
        settings_run = 1;
        set_idle(IDLE_NONE);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings (depth 8, no host bits, zero prefix):
        // every mode on the root, then leaf and penultimate-rank neighbors,
        // range edges of the node ID and unknown mode codes.
        for (int m = MODE_RANK; m <= MODE_BOT_ROUTE; m++)
            send_query(MODE_W'(m), 64'd1 << (TREE_DEPTH_RST - 1));
        for (int n = 0; n < 14; n++)
            send_query(dir_mode[n], dir_node[n]);
        i_in_valid <= 1'b0;
        drain();

        // Random part: depth and host bits through their extremes, including
        // depth zero, depth above the node width, one host bit and prefix too short.
        run_phase(64, 0, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_NONE,
                  PHASE_ITEMS, 1'b1);
        run_phase(8, 8, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_SENDER,
                  PHASE_ITEMS, 1'b0);
        run_phase(1, 64, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_RECEIVER,
                  PHASE_ITEMS, 1'b0);
        run_phase(16, 1, '1, '1, IDLE_BOTH, PHASE_ITEMS, 1'b0);
        run_phase(0, 20, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_NONE, 40, 1'b0);
        run_phase(100, 0, '0, '0, IDLE_SENDER, PHASE_ITEMS, 1'b0);
        run_phase(40, 88, '1, '1, IDLE_RECEIVER, PHASE_ITEMS, 1'b0);
        run_phase(64, 126, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_BOTH,
                  PHASE_ITEMS, 1'b0);
        run_phase(3, 127, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_NONE,
                  PHASE_ITEMS, 1'b0);
        run_phase(24, 64, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_SENDER,
                  PHASE_ITEMS, 1'b0);
        run_phase(127, 2, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_BOTH,
                  PHASE_ITEMS, 1'b0);
        run_phase(63, 32, {$urandom, $urandom}, {$urandom, $urandom}, IDLE_RECEIVER,
                  PHASE_ITEMS, 1'b0);

        // Let any stray result surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d queries over %0d register settings, all modes and unknown codes.",
                 queries_sent, settings_run);
        $display("Answers seen: %0d valid, %0d without result, %0d invalid node.",
                 board.seen_ok, board.seen_none, board.seen_bad);
        if (board.errors == 0 && board.answers_due.size() == 0) begin
            $display("PASS tree_node_ipv6_address_calc_core");
        end else begin
            $display("FAIL tree_node_ipv6_address_calc_core");
        end
        $finish;
    end

endmodule

// File: files.f
sv/tnic_pkg.sv
sv/tnic_decode.sv
sv/tnic_net.sv
sv/tree_node_ipv6_address_calc_core.sv
tb/sv/tnic_tb_pkg.sv
tb/sv/tb_tree_node_ipv6_address_calc_core.sv
